>>> hw/rtl/twsch_pkg.sv
`default_nettype none

package twsch_pkg;

  localparam int WARP_COUNT = 32;
  localparam int MASK_W     = 32;
  localparam int WARP_W     = $clog2(WARP_COUNT);
  localparam int LEN_W      = $clog2(WARP_COUNT + 1);
  localparam int GS_W       = 6;
  localparam int TMO_W      = 16;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [GS_W-1:0]  GS_RESET  = GS_W'(8);
  localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(16);
  localparam logic [TMO_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    REG_GROUP_SIZE    = 1'b0,
    REG_ISSUE_TIMEOUT = 1'b1
  } reg_idx_e;

  // Per-group layout, derived from the group size when it is written
  typedef struct packed {
    logic [WARP_COUNT-1:0][MASK_W-1:0] gmask;
    logic [WARP_COUNT-1:0][WARP_W-1:0] gstart;
    logic [WARP_COUNT-1:0][LEN_W-1:0]  glen;
  } grp_tab_t;

  typedef struct packed {
    grp_tab_t          tab;
    logic [TMO_W-1:0]  tmo;      // timeout with zero read as one
    logic              regroup;  // group size write in this cycle
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/twsch_cfg.sv
`default_nettype none

module twsch_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [twsch_pkg::ADDR_W-1:0] paddr,
  input  wire logic [twsch_pkg::DATA_W-1:0] pwdata,
  output logic      [twsch_pkg::DATA_W-1:0] prdata,
  output logic                              pready,
  output twsch_pkg::cfg_t                   cfg_o
);
  import twsch_pkg::*;

  function automatic grp_tab_t build_tab(logic [GS_W-1:0] gs);
    grp_tab_t t;
    int       eff;
    int       st;
    int       ln;
    t   = '0;
    eff = (gs == '0) ? 1 : int'(gs);
    if (eff > WARP_COUNT) eff = WARP_COUNT;
    for (int g = 0; g < WARP_COUNT; g++) begin
      st = g * eff;
      if (st < WARP_COUNT) begin
        ln = WARP_COUNT - st;
        if (ln > eff) ln = eff;
        t.gstart[g] = WARP_W'(st);
        t.glen[g]   = LEN_W'(ln);
        for (int w = 0; w < MASK_W; w++) begin
          t.gmask[g][w] = (w >= st) && (w < st + ln);
        end
      end
    end
    return t;
  endfunction

  logic [GS_W-1:0]  gs_q;
  logic [TMO_W-1:0] tmo_q;
  grp_tab_t         tab_q;
  logic             wr;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q  <= GS_RESET;
      tmo_q <= TMO_RESET;
      tab_q <= build_tab(GS_RESET);
    end else if (wr) begin
      unique case (idx)
        REG_GROUP_SIZE: begin
          gs_q  <= pwdata[GS_W-1:0];
          tab_q <= build_tab(pwdata[GS_W-1:0]);
        end
        REG_ISSUE_TIMEOUT: tmo_q <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GROUP_SIZE:    prdata = DATA_W'(gs_q);
      REG_ISSUE_TIMEOUT: prdata = DATA_W'(tmo_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.tab     = tab_q;
  assign cfg_o.tmo     = (tmo_q == '0) ? TMO_W'(1) : tmo_q;
  assign cfg_o.regroup = wr && (idx == REG_GROUP_SIZE);

endmodule

`default_nettype wire

>>> hw/rtl/twsch_sel.sv
`default_nettype none

module twsch_sel (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         adv_i,
  input  wire logic [twsch_pkg::MASK_W-1:0] mask_i,
  input  wire twsch_pkg::cfg_t              cfg_i,
  output logic      [twsch_pkg::WARP_W-1:0] warp_id_o,
  output logic                              valid_res_o
);
  import twsch_pkg::*;

  // lowest set bit: {found, index}
  function automatic logic [WARP_W:0] first_set(logic [MASK_W-1:0] v);
    logic [WARP_W:0] r;
    r = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, WARP_W'(i)};
    end
    return r;
  endfunction

  logic [WARP_W-1:0] act_q;
  logic [TMO_W-1:0]  cnt_q;
  logic [WARP_W-1:0] ptr_q [WARP_COUNT];

  logic [WARP_COUNT-1:0]   gready;
  logic [2*WARP_COUNT-1:0] rot;
  logic [WARP_W:0]         oth;
  logic [WARP_W-1:0]       nxt;
  logic                    swap;
  logic [WARP_W-1:0]       grp;
  logic [MASK_W-1:0]       gm;
  logic [MASK_W-1:0]       hi;
  logic [WARP_W:0]         thr;
  logic [WARP_W:0]         pick;
  logic [WARP_W-1:0]       off;
  logic [LEN_W-1:0]        off1;
  logic [WARP_W-1:0]       ptr_d;
  logic [TMO_W-1:0]        cnt_base;
  logic [TMO_W-1:0]        cnt_d;
  logic                    any;

  always_comb begin
    for (int g = 0; g < WARP_COUNT; g++) begin
      gready[g] = |(mask_i & cfg_i.tab.gmask[g]);
    end
  end

  assign any = |mask_i;

  // circular search over the other groups, starting one past the active one;
  // groups beyond the last are never ready, so wrapping at the full count is safe
  assign rot  = {gready, gready} >> ({1'b0, act_q} + (WARP_W + 1)'(1));
  assign oth  = first_set({1'b0, rot[WARP_COUNT-2:0]});
  assign nxt  = act_q + WARP_W'(1) + oth[WARP_W-1:0];
  assign swap = !gready[act_q] || ((cnt_q >= cfg_i.tmo) && oth[WARP_W]);
  assign grp  = swap ? nxt : act_q;

  // first ready warp at or after the group's pointer, else wrap to its start
  assign gm   = mask_i & cfg_i.tab.gmask[grp];
  assign thr  = {1'b0, cfg_i.tab.gstart[grp]} + {1'b0, ptr_q[grp]};
  assign hi   = gm & ({MASK_W{1'b1}} << thr);
  assign pick = first_set((hi != '0) ? hi : gm);
  assign off  = pick[WARP_W-1:0] - cfg_i.tab.gstart[grp];
  assign off1 = LEN_W'(off) + LEN_W'(1);
  assign ptr_d = (off1 == cfg_i.tab.glen[grp]) ? '0 : off1[WARP_W-1:0];

  assign cnt_base = swap ? '0 : cnt_q;
  assign cnt_d    = (cnt_base == COUNT_MAX) ? COUNT_MAX : cnt_base + TMO_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      cnt_q <= '0;
      for (int g = 0; g < WARP_COUNT; g++) ptr_q[g] <= '0;
    end else if (cfg_i.regroup) begin
      act_q <= '0;
      cnt_q <= '0;
      for (int g = 0; g < WARP_COUNT; g++) ptr_q[g] <= '0;
    end else if (adv_i && any) begin
      act_q      <= grp;
      cnt_q      <= cnt_d;
      ptr_q[grp] <= ptr_d;
    end
  end

  assign warp_id_o   = any ? pick[WARP_W-1:0] : '0;
  assign valid_res_o = any;

endmodule

`default_nettype wire

>>> hw/rtl/two_level_warp_scheduler_core.sv
// Two-level warp scheduler.
// Input channel: in_valid_i / in_stall_o carry one ready mask per item, one bit
// per warp. Output channel: out_valid_o / out_stall_i carry one result per item,
// the chosen warp_id_o and valid_res_o (low, with warp 0, for an empty mask).
// An item is taken into the input register, the group and warp choice is made
// from it combinationally, and the result is registered in the output register
// as the item leaves. One item per cycle is sustained while the receiver does
// not stall; the active group, issue count and group pointers are updated as
// each result is registered, so items chain at full rate.
// The APB port holds the group size (address 0) and issue_timeout (address 4);
// writing the group size rebuilds the group layout and restarts the active
// group, count and pointers. Write only while no item is in flight.
// Reset empties both registers, clears the scheduling state and restores
// group size 8, issue_timeout 16. When the receiver stalls, the result holds;
// an empty input register still takes one more item, and in_stall_o is high
// while both registers are full and the receiver stalls.
`default_nettype none

module two_level_warp_scheduler_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [twsch_pkg::MASK_W-1:0] ready_mask_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [twsch_pkg::WARP_W-1:0] warp_id_o,
  output logic                              valid_res_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [twsch_pkg::ADDR_W-1:0] paddr,
  input  wire logic [twsch_pkg::DATA_W-1:0] pwdata,
  output logic      [twsch_pkg::DATA_W-1:0] prdata,
  output logic                              pready
);
  import twsch_pkg::*;

  cfg_t              cfg;
  logic              in_v_q;
  logic [MASK_W-1:0] mask_q;
  logic              out_v_q;
  logic [WARP_W-1:0] warp_q;
  logic              res_q;
  logic              adv;
  logic [WARP_W-1:0] sel_warp;
  logic              sel_res;

  twsch_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  twsch_sel u_sel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .mask_i      (mask_q),
    .cfg_i       (cfg),
    .warp_id_o   (sel_warp),
    .valid_res_o (sel_res)
  );

  assign adv        = in_v_q && !(out_v_q && out_stall_i);
  assign in_stall_o = in_v_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      mask_q <= ready_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      warp_q <= sel_warp;
      res_q  <= sel_res;
    end
  end

  assign out_valid_o = out_v_q;
  assign warp_id_o   = warp_q;
  assign valid_res_o = res_q;

  // a registered result is valid exactly when its mask had a ready warp
  a_res_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_v_q && (res_q == ($past(mask_q) != '0)))
    else $error("result valid flag disagrees with mask");

  // the chosen warp was ready in the mask it came from
  a_pick_is_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (mask_q != '0) |=> (($past(mask_q) >> warp_q) & MASK_W'(1)) != '0)
    else $error("chosen warp was not ready");

  // a held item is neither lost nor altered while the output is blocked
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !adv |=> in_v_q && $stable(mask_q))
    else $error("held item lost");

endmodule

`default_nettype wire

>>> test/two_level_warp_scheduler_core_test.sv
`timescale 1ns / 100ps

module two_level_warp_scheduler_core_test;
  import twsch_pkg::*;

  localparam int HOLD_CYCLES  = 64;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 160;
  localparam int NUM_PHASES   = 12;
  localparam int LONE_ITEMS   = 24;

  typedef struct packed {
    logic [WARP_W-1:0] warp;
    logic              vld;
  } sched_res_t;

  // Mirror of the scheduler state; one expected result per accepted mask
  class sched_scoreboard;
    logic [GS_W-1:0]  gsize;
    logic [TMO_W-1:0] tmo;
    int               act;
    int               cnt;
    int               ptr[WARP_COUNT];
    sched_res_t       exp_q[$];
    int               fails;
    int               n_res;

    function new();
      gsize = GS_RESET;
      tmo   = TMO_RESET;
      fails = 0;
      n_res = 0;
      clear_sched();
    endfunction

    function void clear_sched();
      act = 0;
      cnt = 0;
      foreach (ptr[i]) ptr[i] = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_GROUP_SIZE: begin
          gsize = v[GS_W-1:0];
          clear_sched();
        end
        REG_ISSUE_TIMEOUT: begin
          tmo = v[TMO_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function int eff_gsize();
      return (gsize == '0) ? 1 : int'(gsize);
    endfunction

    function int grp_len(int grp);
      int s;
      int e;
      s = grp * eff_gsize();
      e = s + eff_gsize();
      if (e > WARP_COUNT) e = WARP_COUNT;
      return (e > s) ? e - s : 0;
    endfunction

    function bit grp_ready(logic [MASK_W-1:0] m, int grp);
      int s;
      s = grp * eff_gsize();
      for (int i = 0; i < grp_len(grp); i++) begin
        if (m[s + i]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(logic [MASK_W-1:0] m);
      sched_res_t r;
      int g;
      int ng;
      int t;
      int s;
      int n;
      int off;
      int nx;
      r.warp = '0;
      r.vld  = 1'b0;
      g  = eff_gsize();
      ng = (WARP_COUNT + g - 1) / g;
      t  = (tmo == '0) ? 1 : int'(tmo);
      // empty mask leaves the state alone
      if (m != '0) begin
        if (act >= ng) act = 0;
        if (grp_ready(m, act)) begin
          if (cnt >= t) begin
            for (int i = 1; i < ng; i++) begin
              nx = (act + i) % ng;
              if (grp_ready(m, nx)) begin
                act = nx;
                cnt = 0;
                break;
              end
            end
          end
        end else begin
          for (int i = 1; i <= ng; i++) begin
            act = (act + 1) % ng;
            cnt = 0;
            if (grp_ready(m, act)) break;
          end
        end
        s = act * g;
        n = grp_len(act);
        for (int i = 0; i < n; i++) begin
          off = (ptr[act] % n + i) % n;
          if (m[s + off]) begin
            ptr[act] = (off + 1) % n;
            r.warp   = WARP_W'(s + off);
            r.vld    = 1'b1;
            break;
          end
        end
        if (cnt < int'(COUNT_MAX)) cnt++;
      end
      exp_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fails++;
    endtask

    task check_result(logic [WARP_W-1:0] warp, logic vld);
      sched_res_t e;
      n_res++;
      if (exp_q.size() == 0) begin
        report($sformatf("result warp=%0d valid=%0b with nothing expected", warp, vld));
      end else begin
        e = exp_q.pop_front();
        if (vld !== e.vld)
          report($sformatf("result %0d valid_res=%0b, want %0b", n_res, vld, e.vld));
        if (warp !== e.warp)
          report($sformatf("result %0d warp_id=%0d, want %0d", n_res, warp, e.warp));
      end
    endtask

    function int pending();
      return exp_q.size();
    endfunction
  endclass

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [MASK_W-1:0]   ready_mask_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [WARP_W-1:0]   warp_id_o;
  logic                valid_res_o;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  sched_scoreboard sb = new();

  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;
  bit          long_hold_req = 1'b0;
  int          quiet         = 0;
  int          n_in          = 0;
  int          n_empty       = 0;
  int          n_settings    = 1;
  logic [MASK_W-1:0] last_mask = '0;

  int gs_tab  [NUM_PHASES] = '{8, 8, 1, 0, 32, 63, 63, 5, 3, 16, 31, 4};
  int tmo_tab [NUM_PHASES] = '{16, 2, 1, 0, 5, 65535, 3, 3, 2, 4, 2, 1};

  two_level_warp_scheduler_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ready_mask_i (ready_mask_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .warp_id_o    (warp_id_o),
    .valid_res_o  (valid_res_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Both channels and the watchdog, all from values before the edge
  always @(posedge clk_i) begin
    bit busy;
    busy = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_item(ready_mask_i);
        n_in++;
        if (ready_mask_i == '0) n_empty++;
        busy = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(warp_id_o, valid_res_o);
        busy = 1'b1;
      end
      if (psel && penable && pready) busy = 1'b1;
      quiet = busy ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver stall: short random bursts, or one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic tx_gap();
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i   <= 1'b0;
      ready_mask_i <= $urandom;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(logic [MASK_W-1:0] m);
    tx_gap();
    in_valid_i   <= 1'b1;
    ready_mask_i <= m;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  // the group size is only rewritten when it changes or is 32, so some phases keep their state
  task automatic set_regs(int gs, int t);
    drain();
    if (DATA_W'(gs) != DATA_W'(sb.gsize) || gs == 32)
      apb_write(REG_GROUP_SIZE, DATA_W'(gs));
    apb_write(REG_ISSUE_TIMEOUT, DATA_W'(t));
    n_settings++;
  endtask

  function automatic logic [MASK_W-1:0] rand_mask();
    int g;
    int ng;
    int grp;
    int s;
    int n;
    logic [MASK_W-1:0] gm;
    logic [MASK_W-1:0] m;
    g = sb.eff_gsize();
    if (g > WARP_COUNT) g = WARP_COUNT;
    ng  = (WARP_COUNT + g - 1) / g;
    grp = $urandom_range(0, ng - 1);
    s   = grp * g;
    n   = (s + g > WARP_COUNT) ? WARP_COUNT - s : g;
    gm  = (n == WARP_COUNT) ? '1 : ((MASK_W'(1) << n) - 1) << s;
    case ($urandom_range(0, 15)) inside
      0:       m = '0;
      1:       m = '1;
      2:       m = MASK_W'(1) << $urandom_range(0, 31);
      3, 4, 5: m = $urandom & gm;
      6, 7:    m = ($urandom & gm) | (MASK_W'(1) << $urandom_range(0, 31));
      8, 9:    m = $urandom & $urandom & $urandom;
      10, 11:  m = last_mask;
      default: m = $urandom;
    endcase
    last_mask = m;
    return m;
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset layout: four groups of eight
    send_item('0);
    send_item('1);
    send_item(32'h0000_0001);
    send_item(32'h8000_0000);
    send_item(32'h00F0_0000);
    send_item(32'h5555_5555);
    send_item(32'hAAAA_AAAA);
    send_item('0);

    // zero registers act as one
    set_regs(0, 0);
    send_item('1);
    send_item('1);
    send_item(32'h8000_0001);
    send_item(32'h8000_0001);

    // oversized group: a single group
    set_regs(63, 2);
    repeat (3) send_item('1);
    send_item(32'h0000_0010);

    set_regs(32, 1);
    send_item(32'hFFFF_0000);
    send_item('1);

    // short last group, warps 30 and 31
    set_regs(3, 1);
    send_item(32'h8000_0000);
    send_item(32'hC000_0001);
    send_item(32'hC000_0001);

    // a lone ready group runs past its timeout, then yields once another is ready
    set_regs(16, 20);
    repeat (LONE_ITEMS) send_item(32'h0000_FFFF);
    repeat (4) send_item('1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      set_regs(gs_tab[p], tmo_tab[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 30) long_hold_req = 1'b1;
        if (p == 6 && k == 80) drain();
        send_item(rand_mask());
      end
    end

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    drain();
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Run: %0d masks (%0d empty) under %0d register settings, %0d results checked",
             n_in, n_empty, n_settings, sb.n_res);
    $display("Covered timeouts, odd group sizes, regrouping and receiver back-pressure");
    if (sb.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> two_level_warp_scheduler_core.f
hw/rtl/twsch_pkg.sv
hw/rtl/twsch_cfg.sv
hw/rtl/twsch_sel.sv
hw/rtl/two_level_warp_scheduler_core.sv
test/two_level_warp_scheduler_core_test.sv
